>>> rtl/gelu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared constants for the GELU (tanh form) datapath: internal fixed-point
// widths, scaled coefficients and divider geometry.
// ----------------------------------------------------------------------------
package gelu_pkg;

  // Default sample format: signed Q4.11 in 16 bits
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 11;

  // Internal fixed point: magnitudes carried in Q28
  localparam int QF  = 28;
  localparam int AW  = 31;  // |x| in Q28, below 8.0
  localparam int A2W = 34;  // a^2 in Q28
  localparam int A3W = 37;  // a^3 in Q28
  localparam int UW  = 34;  // inner term and tanh argument u in Q28
  localparam int VW  = 37;  // 2u in Q30
  localparam int RW  = 30;  // reduced argument, below ln2 in Q30
  localparam int PW  = 31;  // series value, up to 1.0 in Q30
  localparam int KW  = 5;   // ln2 multiple count
  localparam int K_MAX = 28;
  localparam int TW  = 29;  // tanh in Q28, up to 1.0
  localparam int MW  = 30;  // 1 +/- tanh in Q28
  localparam int PRW = 61;  // a * m

  // Series and divider geometry
  localparam int SERIES_TERMS = 12;
  localparam int DEN_W        = 32;
  localparam int NUM_W        = 59;
  localparam int QB           = 30;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = QB / DIV_BITS;

  // Scaled coefficients
  localparam logic [29:0] K_SQRT2PI_Q30 = 30'd856722023;
  localparam logic [19:0] K_CUBIC_Q24   = 20'd750193;
  localparam logic [29:0] K_LN2_Q30     = 30'd744261118;

  localparam logic [PW-1:0] ONE30 = PW'(64'd1 << 30);
  localparam logic [TW-1:0] ONE28 = TW'(64'd1 << 28);
  localparam logic [UW-1:0] U_SAT = UW'(64'd10 << 28);

endpackage

>>> rtl/gelu_arg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_arg
// Forms u = sqrt(2/pi) * (a + 0.044715 * a^3) and splits 2u into k*ln2 + r.
// Seven register stages.
// ----------------------------------------------------------------------------
module gelu_arg #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [gelu_pkg::AW-1:0]      a_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic                         sat_o,
  output logic [gelu_pkg::KW-1:0]      k_o,
  output logic [gelu_pkg::RW-1:0]      r_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int AW    = gelu_pkg::AW;
  localparam int A2W   = gelu_pkg::A2W;
  localparam int A3W   = gelu_pkg::A3W;
  localparam int UW    = gelu_pkg::UW;
  localparam int VW    = gelu_pkg::VW;
  localparam int RW    = gelu_pkg::RW;
  localparam int KW    = gelu_pkg::KW;
  localparam int K_MAX = gelu_pkg::K_MAX;
  localparam int NSTG  = 7;

  logic [NSTG-1:0]   vld_q;
  logic [SIDE_W-1:0] side_q [NSTG];

  logic [AW-1:0]  a1_q, a2c_q, a3c_q;
  logic [A2W-1:0] a2_q;
  logic [A3W-1:0] a3_q;
  logic [UW-1:0]  cub_q, inner_q, u_q;
  logic [VW-1:0]  v_q;
  logic [K_MAX-1:0] therm_q;
  logic           sat6_q, sat_q;
  logic [KW-1:0]  k_q;
  logic [RW-1:0]  r_q;

  logic [61:0]    sq, cu;
  logic [56:0]    cb;
  logic [63:0]    up;
  logic [UW-1:0]  inner_d;
  logic [VW-1:0]  v_d;
  logic [K_MAX-1:0] therm_d;
  logic [KW-1:0]  k_d;
  logic [RW-1:0]  r_d;

  assign sq      = 62'(a_i) * 62'(a_i);
  assign cu      = 62'(a2_q) * 62'(a1_q >> 3);
  assign cb      = 57'(a3_q) * 57'(gelu_pkg::K_CUBIC_Q24);
  assign inner_d = UW'(a3c_q) + cub_q;
  assign up      = 64'(inner_q) * 64'(gelu_pkg::K_SQRT2PI_Q30);
  assign v_d     = {u_q, 3'b000};

  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      therm_d[j] = (v_d >= VW'(64'(j + 1) * 64'(gelu_pkg::K_LN2_Q30)));
    end
  end

  // Highest set thermometer bit gives k = floor(2u / ln2)
  always_comb begin
    logic [VW-1:0] kl;
    kl  = '0;
    k_d = '0;
    for (int j = 0; j < K_MAX; j++) begin
      if (therm_q[j]) begin
        k_d = KW'(j + 1);
        kl  = VW'(64'(j + 1) * 64'(gelu_pkg::K_LN2_Q30));
      end
    end
    r_d = RW'(v_q - kl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NSTG; s++) begin
        side_q[s] <= side_q[s-1];
      end
      a1_q    <= a_i;
      a2_q    <= sq[61:28];
      a2c_q   <= a1_q;
      a3_q    <= cu[61:25];
      a3c_q   <= a2c_q;
      cub_q   <= UW'(cb[56:24]);
      inner_q <= inner_d;
      u_q     <= up[63:30];
      sat6_q  <= (u_q >= gelu_pkg::U_SAT);
      v_q     <= v_d;
      therm_q <= therm_d;
      sat_q   <= sat6_q;
      k_q     <= k_d;
      r_q     <= r_d;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];
  assign sat_o   = sat_q;
  assign k_o     = k_q;
  assign r_o     = r_q;

endmodule

>>> rtl/gelu_exp_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_exp_term
// One Horner step of the exp(-r) series: p' = 1 - round(r * p / N).
// Three register stages; the divide by N is a reciprocal multiply with a
// single correction.
// ----------------------------------------------------------------------------
module gelu_exp_term #(
  parameter int N      = 1,
  parameter int SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [gelu_pkg::RW-1:0] r_i,
  input  logic [gelu_pkg::PW-1:0] p_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [gelu_pkg::RW-1:0] r_o,
  output logic [gelu_pkg::PW-1:0] p_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int RW = gelu_pkg::RW;
  localparam int PW = gelu_pkg::PW;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

  logic [2:0]        vld_q;
  logic [SIDE_W-1:0] side_a_q, side_b_q, side_c_q;
  logic [RW-1:0]     r_a_q, r_b_q, r_c_q;
  logic [60:0]       x_q;
  logic [PW-1:0]     y_q;
  logic [63:0]       prod_q;
  logic [PW-1:0]     p_q;

  logic [61:0] ysum;
  logic [PW-1:0] y_d;
  logic [63:0] prod_d;
  logic [PW-1:0] q0;
  logic [34:0] rem;
  logic [31:0] q;
  logic [PW-1:0] p_d;

  assign ysum   = 62'(x_q) + (62'(N) << 29);
  assign y_d    = PW'(ysum >> 30);
  assign prod_d = 64'(y_d) * 64'(RECIP);

  // Quotient estimate is exact or one short; fix it from the remainder
  assign q0  = prod_q[62:32];
  assign rem = 35'(y_q) - 35'(q0) * 35'(N);
  assign q   = 32'(q0) + 32'(rem >= 35'(N));
  assign p_d = (q >= 32'(gelu_pkg::ONE30)) ? '0 : PW'(32'(gelu_pkg::ONE30) - q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= 61'(r_i) * 61'(p_i);
      r_a_q    <= r_i;
      side_a_q <= side_i;
      y_q      <= y_d;
      prod_q   <= prod_d;
      r_b_q    <= r_a_q;
      side_b_q <= side_a_q;
      p_q      <= p_d;
      r_c_q    <= r_b_q;
      side_c_q <= side_b_q;
    end
  end

  assign valid_o = vld_q[2];
  assign r_o     = r_c_q;
  assign p_o     = p_q;
  assign side_o  = side_c_q;

endmodule

>>> rtl/gelu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_div
// Pipelined restoring divider: quotient of num by den, two quotient bits
// per register stage.
// ----------------------------------------------------------------------------
module gelu_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [gelu_pkg::NUM_W-1:0] num_i,
  input  logic [gelu_pkg::DEN_W-1:0] den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [gelu_pkg::QB-1:0]    quo_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int QB    = gelu_pkg::QB;
  localparam int DEN_W = gelu_pkg::DEN_W;
  localparam int REM_W = DEN_W;
  localparam int TRW   = REM_W + 1;
  localparam int NSTG  = gelu_pkg::DIV_STAGES;

  logic [NSTG-1:0]   vld_q;
  logic [REM_W-1:0]  rem_q [NSTG];
  logic [QB-1:0]     low_q [NSTG];
  logic [QB-1:0]     quo_q [NSTG];
  logic [DEN_W-1:0]  den_q [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  logic [REM_W-1:0]  rem_d [NSTG];
  logic [QB-1:0]     low_d [NSTG];
  logic [QB-1:0]     quo_d [NSTG];
  logic [DEN_W-1:0]  den_d [NSTG];
  logic [SIDE_W-1:0] side_d [NSTG];

  always_comb begin
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    low, quo;
    logic [DEN_W-1:0] den;
    logic [TRW-1:0]   trial;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        rem       = REM_W'(num_i >> QB);
        low       = num_i[QB-1:0];
        quo       = '0;
        den       = den_i;
        side_d[s] = side_i;
      end else begin
        rem       = rem_q[s-1];
        low       = low_q[s-1];
        quo       = quo_q[s-1];
        den       = den_q[s-1];
        side_d[s] = side_q[s-1];
      end
      for (int b = 0; b < gelu_pkg::DIV_BITS; b++) begin
        trial = {rem, low[QB-1]};
        low   = low << 1;
        if (trial >= TRW'(den)) begin
          rem = REM_W'(trial - TRW'(den));
          quo = {quo[QB-2:0], 1'b1};
        end else begin
          rem = trial[REM_W-1:0];
          quo = {quo[QB-2:0], 1'b0};
        end
      end
      rem_d[s] = rem;
      low_d[s] = low;
      quo_d[s] = quo;
      den_d[s] = den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NSTG; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_d[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_d[s];
        side_q[s] <= side_d[s];
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

>>> rtl/gelu_tanh_activation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gelu_tanh_activation
// Streaming GELU, tanh approximation, on signed fixed-point samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one sample x_in_i in
//   signed Q(W-F).F plus a last_in_i tensor marker. Output channel
//   (out_valid_o / out_ready_i) returns y_out_o = GELU(x), rounded to
//   nearest (ties away from zero) and saturated, with last_out_o copied.
//   Throughput: one item per cycle unless the receiver stalls; every stage
//   is fully pipelined. The depth comes from the 12-term exp series (3
//   stages per term) and the radix-4 tanh divider (15 stages).
//   Flow control: one advance enable moves all stages together. It is high
//   when the output register is empty or being taken, so a stalled receiver
//   freezes the whole pipe; nothing is dropped or duplicated, and bubbles
//   travel as cleared valid bits.
//   Reset (rst_ni low, async) clears every valid bit; data registers are
//   not reset. No configuration, no clearing pass.
// ----------------------------------------------------------------------------
module gelu_tanh_activation #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] x_in_i,
  input  logic                  last_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] y_out_o,
  output logic                  last_out_o
);

  localparam int W     = DATA_WIDTH;
  localparam int AW    = gelu_pkg::AW;
  localparam int KW    = gelu_pkg::KW;
  localparam int RW    = gelu_pkg::RW;
  localparam int PW    = gelu_pkg::PW;
  localparam int TW    = gelu_pkg::TW;
  localparam int MW    = gelu_pkg::MW;
  localparam int PRW   = gelu_pkg::PRW;
  localparam int QB    = gelu_pkg::QB;
  localparam int DEN_W = gelu_pkg::DEN_W;
  localparam int NUM_W = gelu_pkg::NUM_W;
  localparam int NT    = gelu_pkg::SERIES_TERMS;
  localparam int SH    = 57 - FRAC_BITS;       // Q56 product down to result scale
  localparam int YMW   = FRAC_BITS + 4;        // rounded magnitude width
  localparam logic [63:0] BIG_LIM = 64'd8 << FRAC_BITS;
  localparam logic [63:0] POSMAX  = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [63:0] NEGMAX  = 64'd1 << (W - 1);

  // Per-item fields that ride along the whole pipe
  typedef struct packed {
    logic [W-1:0]  x;
    logic          last;
    logic          neg;
    logic          big;   // |x| >= 8.0: result is x or 0
    logic [AW-1:0] a;     // |x| in Q28
  } side_t;

  typedef struct packed {
    logic          sat;   // u >= 10: tanh is exactly 1
    logic [KW-1:0] k;
    side_t         s;
  } side1_t;

  typedef struct packed {
    logic  sat;
    side_t s;
  } tail_t;

  localparam int SIDE_W  = $bits(side_t);
  localparam int SIDE1_W = $bits(side1_t);
  localparam int TAIL_W  = $bits(tail_t);

  // Global advance: move everything when the output slot frees up
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---- Input register ----
  logic         v1_q;
  logic [W-1:0] x1_q;
  logic         last1_q;

  // ---- Prep: sign, magnitude, Q28 scaling ----
  logic         neg_d, big_d;
  logic [W:0]   mag_d;
  logic [AW-1:0] a_d;
  logic         v2_q;
  side_t        side2_q;

  assign neg_d = x1_q[W-1];
  assign mag_d = neg_d ? ({1'b1, W'(0)} - {1'b0, x1_q}) : {1'b0, x1_q};
  assign big_d = (64'(mag_d) >= BIG_LIM);
  assign a_d   = AW'(64'(mag_d) << (gelu_pkg::QF - FRAC_BITS));

  // ---- Argument and ln2 range reduction ----
  logic          arg_valid, arg_sat;
  logic [KW-1:0] arg_k;
  logic [RW-1:0] arg_r;
  logic [SIDE_W-1:0] arg_side;

  gelu_arg #(
    .SIDE_W (SIDE_W)
  ) u_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .a_i     (side2_q.a),
    .side_i  (side2_q),
    .valid_o (arg_valid),
    .sat_o   (arg_sat),
    .k_o     (arg_k),
    .r_o     (arg_r),
    .side_o  (arg_side)
  );

  // ---- exp(-r) series, highest term first ----
  logic               vs [NT+1];
  logic [RW-1:0]      rs [NT+1];
  logic [PW-1:0]      ps [NT+1];
  logic [SIDE1_W-1:0] ss [NT+1];
  side1_t             side1_in;

  assign side1_in = '{sat: arg_sat, k: arg_k, s: side_t'(arg_side)};
  assign vs[0] = arg_valid;
  assign rs[0] = arg_r;
  assign ps[0] = gelu_pkg::ONE30;
  assign ss[0] = side1_in;

  for (genvar i = 0; i < NT; i++) begin : g_term
    gelu_exp_term #(
      .N      (NT - i),
      .SIDE_W (SIDE1_W)
    ) u_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vs[i]),
      .r_i     (rs[i]),
      .p_i     (ps[i]),
      .side_i  (ss[i]),
      .valid_o (vs[i+1]),
      .r_o     (rs[i+1]),
      .p_o     (ps[i+1]),
      .side_o  (ss[i+1])
    );
  end

  // ---- Scale by 2^-k with rounding: e = exp(-2u) ----
  side1_t        ser_side;
  logic [31:0]   e_sum;
  logic [PW-1:0] e_d;
  logic          ve_q;
  logic [PW-1:0] e_q;
  tail_t         te_q;

  assign ser_side = side1_t'(ss[NT]);
  assign e_sum    = 32'(ps[NT]) + (32'd1 << (ser_side.k - KW'(1)));
  assign e_d      = (ser_side.k == '0) ? ps[NT] : PW'(e_sum >> ser_side.k);

  // ---- tanh = (1 - e) / (1 + e): set up dividend and divisor ----
  logic [DEN_W-1:0] den_d;
  logic [NUM_W-1:0] num_d;
  logic             vd_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] num_q;
  tail_t            td_q;

  assign den_d = DEN_W'(gelu_pkg::ONE30) + DEN_W'(e_q);
  assign num_d = (NUM_W'(gelu_pkg::ONE30 - e_q) << 28) + NUM_W'(den_d >> 1);

  logic              div_valid;
  logic [QB-1:0]     div_quo;
  logic [TAIL_W-1:0] div_side;

  gelu_div #(
    .SIDE_W (TAIL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (td_q),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // ---- m = 1 + tanh for positive x, 1 - tanh for negative x ----
  tail_t         dv_side;
  logic [TW-1:0] t_d;
  logic [MW-1:0] m_d;
  logic          vm_q;
  logic [MW-1:0] m_q;
  side_t         sm_q;

  assign dv_side = tail_t'(div_side);
  assign t_d     = dv_side.sat ? gelu_pkg::ONE28 : div_quo[TW-1:0];
  assign m_d     = dv_side.s.neg ? (MW'(gelu_pkg::ONE28) - MW'(t_d))
                                 : (MW'(gelu_pkg::ONE28) + MW'(t_d));

  // ---- Product a * m (twice the result, Q56) ----
  logic           vp_q;
  logic [PRW-1:0] prod_q;
  side_t          sp_q;

  // ---- Round, saturate, sign, large-input bypass ----
  logic [PRW-1:0] rsum;
  logic [YMW-1:0] ymag;
  logic [63:0]    ym64, lim, yc;
  logic [W-1:0]   y_d;

  assign rsum = prod_q + (PRW'(1) << (SH - 1));
  assign ymag = YMW'(rsum >> SH);
  assign ym64 = 64'(ymag);
  assign lim  = sp_q.neg ? NEGMAX : POSMAX;
  assign yc   = (ym64 > lim) ? lim : ym64;

  always_comb begin
    if (sp_q.big) begin
      y_d = sp_q.neg ? '0 : sp_q.x;
    end else if (sp_q.neg) begin
      y_d = W'(64'd0 - yc);
    end else begin
      y_d = W'(yc);
    end
  end

  logic         vo_q;
  logic [W-1:0] y_q;
  logic         lo_q;

  // Valid bits: cleared at reset, advance with the enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ve_q <= 1'b0;
      vd_q <= 1'b0;
      vm_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      ve_q <= vs[NT];
      vd_q <= ve_q;
      vm_q <= div_valid;
      vp_q <= vm_q;
      vo_q <= vp_q;
    end
  end

  // Data registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= x_in_i;
      last1_q <= last_in_i;
      side2_q <= '{x: x1_q, last: last1_q, neg: neg_d, big: big_d, a: a_d};
      e_q     <= e_d;
      te_q    <= '{sat: ser_side.sat, s: ser_side.s};
      den_q   <= den_d;
      num_q   <= num_d;
      td_q    <= te_q;
      m_q     <= m_d;
      sm_q    <= dv_side.s;
      prod_q  <= PRW'(sm_q.a) * PRW'(m_q);
      sp_q    <= sm_q;
      y_q     <= y_d;
      lo_q    <= sp_q.last;
    end
  end

  assign out_valid_o = vo_q;
  assign y_out_o     = y_q;
  assign last_out_o  = lo_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming GELU (tanh form) block. Samples go in
// over a valid/ready channel and every result is compared, value and last
// flag, against a bit-exact integer model of the same fixed-point recipe
// held here. Both channels idle at random, with one stretch at full rate and
// pauses that let the pipe drain completely.
// ----------------------------------------------------------------------------
module tb;

  localparam int DW = gelu_pkg::DATA_WIDTH_DEF;
  localparam int FB = gelu_pkg::FRAC_BITS_DEF;

  // Fixed-point constants of the GELU recipe
  localparam int unsigned TERMS       = 12;
  localparam longint unsigned SQRT2PI = 64'd856722023;  // sqrt(2/pi), Q30
  localparam longint unsigned CUBIC   = 64'd750193;     // 0.044715, Q24
  localparam longint unsigned LN2     = 64'd744261118;  // ln2, Q30
  localparam longint unsigned Q28_ONE = 64'd1 << 28;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam int unsigned ROUND_SH    = 57 - FB;

  localparam int IDLE_PCT     = 29;
  localparam int DRAIN_CYCLES = 80;   // pipe is 65 deep
  localparam int MAX_PRINTS   = 40;

  typedef bit [63:0] u64_t;

  typedef struct packed {
    logic [DW-1:0] y;
    logic          last;
  } gelu_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] x_in = '0;
  logic          last_in = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] y_out;
  logic          last_out;

  // Hold both sides at full rate while set
  bit steady = 1'b0;

  gelu_result_t gelu_pending[$];
  int           mismatches = 0;
  int           samples_sent = 0;
  int           results_checked = 0;

  gelu_tanh_activation u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .x_in_i      (x_in),
    .last_in_i   (last_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .y_out_o     (y_out),
    .last_out_o  (last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: integer GELU with the same Q28/Q30 steps as the hardware
  // --------------------------------------------------------------------------

  // exp(-r) for r in [0, ln2), by a Horner series; Q30 in and out
  function automatic u64_t exp_neg_q30(u64_t r);
    u64_t p;
    u64_t den;
    u64_t q;
    int   n;
    p = Q30_ONE;
    for (n = TERMS; n >= 1; n--) begin
      den = u64_t'(n) << 30;
      q   = (r * p + (den >> 1)) / den;
      p   = (q >= Q30_ONE) ? 64'd0 : (Q30_ONE - q);
    end
    return p;
  endfunction

  // tanh(u) for u >= 0 as (1 - e) / (1 + e), e = exp(-2u); Q28 in and out
  function automatic u64_t tanh_q28(u64_t u);
    u64_t v;
    u64_t k;
    u64_t r;
    u64_t e;
    u64_t num;
    u64_t den;
    // Clip at a large argument (u >= 10): tanh is taken as exactly 1.0
    if (u >= (64'd10 << 28)) return Q28_ONE;
    v = u << 3;
    k = v / LN2;
    r = v - k * LN2;
    e = exp_neg_q30(r);
    if (k > 40) e = 64'd0;
    else if (k != 0) e = (e + (64'd1 << (k - 1))) >> k;
    num = (Q30_ONE - e) << 28;
    den = Q30_ONE + e;
    return (num + (den >> 1)) / den;
  endfunction

  function automatic logic [DW-1:0] gelu_of(logic [DW-1:0] x);
    u64_t raw;
    u64_t mag;
    u64_t ymag;
    u64_t a;
    u64_t a2;
    u64_t a3;
    u64_t inner;
    u64_t u;
    u64_t t;
    u64_t m;
    bit   neg;
    raw = u64_t'(x);
    neg = x[DW-1];
    mag = neg ? ((64'd1 << DW) - raw) : raw;
    if (mag >= (64'd8 << FB)) begin
      // Large magnitude: pass positives, zero negatives
      ymag = neg ? 64'd0 : mag;
    end else begin
      a     = mag << (28 - FB);
      a2    = (a * a) >> 28;
      a3    = (a2 * (a >> 3)) >> 25;
      inner = a + ((a3 * CUBIC) >> 24);
      u     = (inner * SQRT2PI) >> 30;
      t     = tanh_q28(u);
      m     = neg ? (Q28_ONE - t) : (Q28_ONE + t);
      // Round the half product to nearest, ties away from zero
      ymag  = (a * m + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    end
    if (neg) begin
      if (ymag > (64'd1 << (DW - 1))) ymag = 64'd1 << (DW - 1);
      return DW'((64'd1 << DW) - ymag);
    end
    if (ymag > ((64'd1 << (DW - 1)) - 1)) ymag = (64'd1 << (DW - 1)) - 1;
    return DW'(ymag);
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  // Predict every item the block takes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      gelu_pending.push_back('{y: gelu_of(x_in), last: last_in});
      samples_sent++;
    end
  end

  // Compare every result the block hands over against the oldest prediction
  always @(posedge clk) begin
    gelu_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (gelu_pending.size() == 0) begin
        report_mismatch($sformatf("result y=%h with nothing outstanding", y_out));
      end else begin
        want = gelu_pending.pop_front();
        results_checked++;
        if (y_out !== want.y)
          report_mismatch($sformatf("y_out %h, want %h", y_out, want.y));
        if (last_out !== want.last)
          report_mismatch($sformatf("last_out %b, want %b (y=%h)",
                                    last_out, want.last, want.y));
      end
    end
  end

  // Receiver: stall at random unless running at full rate
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one item, idling first at random; leave valid up on return so a
  // following item can go back to back
  task automatic send_item(input logic [DW-1:0] x, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_in     <= x;
    last_in  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold until every prediction has been matched
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gelu_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] signed_sample(int unsigned mag, bit neg);
    return neg ? DW'(-int'(mag)) : DW'(mag);
  endfunction

  // Zero, smallest steps, the tanh clip near 5.4, the 8.0 bypass edge and
  // the format extremes, all but zero with both signs
  task automatic test_directed();
    logic [DW-1:0] corners[$];
    int i;
    corners = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'hFFFE, 16'd1024, 16'hFC00,
                16'd2048, 16'hF800, 16'd4096, 16'hF000, 16'd6144, 16'hE800,
                16'd11059, 16'hD4CD, 16'd12288, 16'hD000, 16'd16383,
                16'hC001, 16'd16384, 16'hC000, 16'h7FFF, 16'h8000};
    for (i = 0; i < corners.size(); i++)
      send_item(corners[i], (i % 5 == 4) || (i == corners.size() - 1));
  endtask

  // Mostly the region where tanh does real work, plus the full 16-bit range
  // so every input bit toggles, with stretches near the clip and bypass edges
  task automatic test_random_mix(input int count);
    int          i;
    int unsigned sel;
    int unsigned mag;
    logic [DW-1:0] x;
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        x = DW'($urandom);
      end else begin
        if (sel < 55)      mag = $urandom_range(16383);
        else if (sel < 75) mag = $urandom_range(512);
        else if (sel < 88) mag = $urandom_range(11300, 10800);
        else               mag = $urandom_range(16400, 16360);
        x = signed_sample(mag, $urandom_range(1));
      end
      send_item(x, $urandom_range(15) == 0);
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back(input int count);
    drain_pipe();
    steady = 1'b1;
    test_random_mix(count);
    drain_pipe();
    steady = 1'b0;
  endtask

  // Let the pipe run empty mid-stream, then resume
  task automatic test_drain_pause();
    test_random_mix(40);
    drain_pipe();
    test_random_mix(40);
    drain_pipe();
    test_random_mix(20);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(300);
    test_back_to_back(150);
    test_drain_pause();
    test_random_mix(300);

    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gelu_pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", gelu_pending.size()));

    $display("Sent %0d samples (directed corners, random mix, full-rate run,",
             samples_sent);
    $display("mid-stream drain); checked %0d results, %0d errors.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond any legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
